// ----- hw/rtl/svo_pkg.sv -----
// ----------------------------------------------------------------------------
// svo_pkg - shared types and constants of the servo sine oscillator
// Configuration layout, queue entry format and the sine table builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svo_pkg;

    // sine table, power of two entries between 64 and 4096
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_IDX_W   = $clog2(SINE_ENTRIES);

    // job queue between the front and the back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_BITS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIM          = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLEW      = 3'd7;

    // bit positions in mode_bits
    localparam int MODE_STOPPED  = 0;
    localparam int MODE_REVERSED = 1;

    // register values after reset
    localparam logic [9:0]        RST_SAMPLE_PERIOD = 10'd30;
    localparam logic [15:0]       RST_PHASE_STEP    = 16'd993;
    localparam logic [7:0]        RST_AMPLITUDE     = 8'd45;
    localparam logic signed [8:0] RST_CENTER_OFFSET = 9'sd0;
    localparam logic [15:0]       RST_START_PHASE   = 16'd0;
    localparam logic [1:0]        RST_MODE_BITS     = 2'd0;
    localparam logic signed [7:0] RST_TRIM          = 8'sd0;
    localparam logic [9:0]        RST_MAX_SLEW      = 10'd0;

    localparam logic signed [9:0] RST_ANGLE = 10'sd90;

    typedef struct packed {
        logic [9:0]        sample_period_ms;
        logic [15:0]       phase_step;
        logic [7:0]        amplitude;
        logic signed [8:0] center_offset;
        logic [15:0]       start_phase;
        logic [1:0]        mode_bits;
        logic signed [7:0] trim;
        logic [9:0]        max_slew;
    } t_cfg;

    // one write request for the back end
    typedef struct packed {
        logic                  is_sample;
        logic [SINE_IDX_W-1:0] sine_idx;
        logic signed [9:0]     target;
        logic [15:0]           age;
    } t_job;

    typedef logic signed [15:0] t_sine_rom [SINE_ENTRIES];

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // quarter-wave reduction, taylor series to x^13 in q30, round half up to q14
    function automatic logic signed [15:0] sine_entry(input int unsigned i);
        logic [63:0] u;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] res;
        logic [1:0]  quad;
        u    = 64'(i) << (32 - SINE_IDX_W);
        quad = u[31:30];
        r    = {34'd0, u[29:0]};
        if (quad[0]) begin
            r = Q30_ONE - r;
        end
        x    = q30_mul(r, PI_HALF_Q30);
        x2   = q30_mul(x, x);
        pos  = x;
        term = q30_mul(x, x2) / 64'd6;
        neg  = term;
        term = q30_mul(term, x2) / 64'd20;
        pos  = pos + term;
        term = q30_mul(term, x2) / 64'd42;
        neg  = neg + term;
        term = q30_mul(term, x2) / 64'd72;
        pos  = pos + term;
        term = q30_mul(term, x2) / 64'd110;
        neg  = neg + term;
        term = q30_mul(term, x2) / 64'd156;
        pos  = pos + term;
        res  = (pos > neg) ? ((pos - neg + 64'd32768) >> 16) : 64'd0;
        if (res > 64'd16384) begin
            res = 64'd16384;
        end
        return quad[1] ? -$signed(res[15:0]) : $signed(res[15:0]);
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

endpackage

// ----- hw/rtl/servo_sine_oscillator_core.sv -----
// ----------------------------------------------------------------------------
// servo_sine_oscillator_core - servo sine oscillator with slew limit
// Millisecond ticks drive a sine sampled into a slew-limited servo angle and
// a 13-bit duty; direct position commands bypass the oscillator.
// ----------------------------------------------------------------------------
// A tick that takes no sample, or a sample while stopped, is taken and
// yields no transaction. A sample or a position command becomes a job in
// a four-entry queue; the back end takes each job through its steps (sine
// table read with product, target, slew step, duty multiply) and takes up
// the next job only when the duty step hands on its result, which waits
// in an output register; the input takes transactions while the queue has
// room. The user must write configuration through the plain write port only
// while the block is idle (the block does not enforce it); writes take effect at once.
`timescale 1ns / 1ps

module servo_sine_oscillator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [15:0]                   i_s_axis_tdata,   // target_angle[9:0], zero fill
    input  logic                          i_s_axis_tuser,   // kind[0]
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [23:0]                   o_m_axis_tdata,   // duty[12:0], angle[20:13], zero fill
    input  logic                          i_cfg_we,
    input  logic [svo_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [svo_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import svo_pkg::*;

    t_cfg r_cfg;

    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              f_push;
    t_job              f_job;
    t_job              q_job;
    logic signed [9:0] s_target;

    assign s_target = $signed(i_s_axis_tdata[9:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_period_ms <= RST_SAMPLE_PERIOD;
            r_cfg.phase_step       <= RST_PHASE_STEP;
            r_cfg.amplitude        <= RST_AMPLITUDE;
            r_cfg.center_offset    <= RST_CENTER_OFFSET;
            r_cfg.start_phase      <= RST_START_PHASE;
            r_cfg.mode_bits        <= RST_MODE_BITS;
            r_cfg.trim             <= RST_TRIM;
            r_cfg.max_slew         <= RST_MAX_SLEW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_PERIOD: r_cfg.sample_period_ms <= i_cfg_data[9:0];
                CFG_PHASE_STEP:    r_cfg.phase_step       <= i_cfg_data[15:0];
                CFG_AMPLITUDE:     r_cfg.amplitude        <= i_cfg_data[7:0];
                CFG_CENTER_OFFSET: r_cfg.center_offset    <= $signed(i_cfg_data[8:0]);
                CFG_START_PHASE:   r_cfg.start_phase      <= i_cfg_data[15:0];
                CFG_MODE_BITS:     r_cfg.mode_bits        <= i_cfg_data[1:0];
                CFG_TRIM:          r_cfg.trim             <= $signed(i_cfg_data[7:0]);
                CFG_MAX_SLEW:      r_cfg.max_slew         <= i_cfg_data[9:0];
            endcase
        end
    end

    svo_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_kind       (i_s_axis_tuser),
        .i_target     (s_target),
        .i_queue_full (q_full),
        .o_push       (f_push),
        .o_job        (f_job)
    );

    svo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    svo_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_job_valid     (q_valid),
        .i_job           (q_job),
        .o_pop           (q_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// ----- hw/rtl/svo_front.sv -----
// ----------------------------------------------------------------------------
// svo_front - tick handling and job issue
// Keeps the sample timer, the command age and the phase accumulator, and
// turns each accepted transaction into at most one job for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svo_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  svo_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic signed [9:0] i_target,
    input  logic              i_queue_full,
    output logic              o_push,
    output svo_pkg::t_job     o_job
);
    import svo_pkg::*;

    logic [15:0] r_phase, n_phase;
    logic [9:0]  r_timer, n_timer;
    logic [15:0] r_age, n_age;

    logic        accept;
    logic [9:0]  timer_inc;
    logic [15:0] age_inc;
    logic        due;
    logic [15:0] phase_sum;

    always_comb begin
        accept    = i_valid && !i_queue_full;
        timer_inc = (r_timer == '1) ? r_timer : r_timer + 10'd1;
        age_inc   = (r_age == '1) ? r_age : r_age + 16'd1;
        due       = (timer_inc >= i_cfg.sample_period_ms);
        phase_sum = r_phase + i_cfg.start_phase;

        n_phase = r_phase;
        n_timer = r_timer;
        n_age   = r_age;
        o_push  = 1'b0;

        o_job.is_sample = 1'b0;
        o_job.sine_idx  = phase_sum[15 -: SINE_IDX_W];
        o_job.target    = i_target;
        o_job.age       = r_age;

        if (accept) begin
            if (i_kind) begin
                // direct command, no time passes
                o_push = 1'b1;
                n_age  = '0;
            end else begin
                n_timer = due ? '0 : timer_inc;
                n_age   = age_inc;
                if (due) begin
                    n_phase = r_phase + i_cfg.phase_step;
                    if (!i_cfg.mode_bits[MODE_STOPPED]) begin
                        o_push          = 1'b1;
                        o_job.is_sample = 1'b1;
                        o_job.age       = age_inc;
                        n_age           = '0;
                    end
                end
            end
        end
    end

    assign o_ready = !i_queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_timer <= '0;
            r_age   <= '0;
        end else begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_age   <= n_age;
        end
    end

endmodule

// ----- hw/rtl/svo_queue.sv -----
// ----------------------------------------------------------------------------
// svo_queue - short job queue
// Holds jobs from the front end until the back end takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svo_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  svo_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output svo_pkg::t_job o_job
);
    import svo_pkg::*;

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count, n_count;

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    assign o_full  = (r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ----- hw/rtl/svo_back.sv -----
// ----------------------------------------------------------------------------
// svo_back - sample evaluation, slew limit and duty conversion
// Four-step sequencer: sine product, target, slew step, duty; the result
// sits in an output register until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svo_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  svo_pkg::t_cfg i_cfg,
    input  logic          i_job_valid,
    input  svo_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [23:0]   o_m_axis_tdata    // duty[12:0], angle[20:13], zero fill
);
    import svo_pkg::*;

    // floor(x/1000) for x below 1024000, and floor(v*8191/1800) for v up to 225
    localparam logic [20:0] RECIP_1000  = 21'd1073742;
    localparam logic [34:0] DUTY_RECIP  = 35'd19544487763;
    localparam logic [25:0] SLEW_CAP    = 26'd1024000;
    localparam logic [19:0] SLEW_CAP_M1 = 20'd1023999;

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_TGT  = 5'b00100,
        S_MOVE = 5'b01000,
        S_DUTY = 5'b10000
    } t_back_state;

    t_back_state r_state;

    t_job               r_job;
    logic signed [15:0] r_sine;
    logic [25:0]        r_slew_prod;
    logic signed [24:0] r_prod;
    logic [9:0]         r_limq;
    logic signed [9:0]  r_target;
    logic signed [9:0]  r_cur;
    logic [7:0]         r_ang;
    logic               r_out_valid;
    logic [23:0]        r_out_data;

    logic               slot_free;
    logic [19:0]        slew_x;
    logic [40:0]        lim_prod;
    logic [24:0]        prod_mag;
    logic [24:0]        prod_rnd_w;
    logic [8:0]         prod_rnd;
    logic signed [11:0] sine_pos;
    logic signed [11:0] tgt_wide;
    logic signed [9:0]  sample_target;
    logic signed [10:0] diff;
    logic [10:0]        diff_mag;
    logic [9:0]         slew_limit;
    logic signed [10:0] cur_step;
    logic signed [9:0]  n_cur;
    logic signed [10:0] trimmed;
    logic [7:0]         ang_clamped;
    logic [8:0]         duty_in;
    logic [44:0]        duty_prod;
    logic [12:0]        duty;

    always_comb begin
        slot_free = !r_out_valid || i_m_axis_tready;
        o_pop     = i_job_valid && ((r_state == S_IDLE) || ((r_state == S_DUTY) && slot_free));

        // slew limit quotient, large products clip to a limit that never binds
        slew_x   = (r_slew_prod >= SLEW_CAP) ? SLEW_CAP_M1 : r_slew_prod[19:0];
        lim_prod = 41'(slew_x) * 41'(RECIP_1000);

        // round amplitude * sine from q14, half away from zero
        prod_mag   = (r_prod < 0) ? 25'(-r_prod) : 25'(r_prod);
        prod_rnd_w = (prod_mag + 25'd8192) >> 14;
        prod_rnd   = prod_rnd_w[8:0];
        sine_pos   = (r_prod < 0) ? -$signed({3'b000, prod_rnd}) : $signed({3'b000, prod_rnd});
        sine_pos   = sine_pos + {{3{i_cfg.center_offset[8]}}, i_cfg.center_offset};
        if (i_cfg.mode_bits[MODE_REVERSED]) begin
            sine_pos = -sine_pos;
        end
        tgt_wide = sine_pos + 12'sd90;
        if (tgt_wide > 12'sd511) begin
            sample_target = 10'sd511;
        end else if (tgt_wide < -12'sd512) begin
            sample_target = -10'sd512;
        end else begin
            sample_target = tgt_wide[9:0];
        end

        // slew step toward the target
        diff       = {r_target[9], r_target} - {r_cur[9], r_cur};
        diff_mag   = (diff < 0) ? 11'(-diff) : 11'(diff);
        slew_limit = (r_limq == '0) ? 10'd1 : r_limq;
        cur_step   = (diff < 0) ? ({r_cur[9], r_cur} - $signed({1'b0, slew_limit}))
                                : ({r_cur[9], r_cur} + $signed({1'b0, slew_limit}));
        if ((i_cfg.max_slew != '0) && (diff_mag > {1'b0, slew_limit})) begin
            n_cur = cur_step[9:0];
        end else begin
            n_cur = r_target;
        end

        trimmed = {n_cur[9], n_cur} + {{3{i_cfg.trim[7]}}, i_cfg.trim};
        if (trimmed < 0) begin
            ang_clamped = 8'd0;
        end else if (trimmed > 11'sd180) begin
            ang_clamped = 8'd180;
        end else begin
            ang_clamped = trimmed[7:0];
        end

        duty_in   = {1'b0, r_ang} + 9'd45;
        duty_prod = 45'(duty_in) * 45'(DUTY_RECIP);
        duty      = duty_prod[44:32];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cur       <= RST_ANGLE;
        end else begin
            if ((r_state == S_DUTY) && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL:  r_state <= S_TGT;
                S_TGT:  r_state <= S_MOVE;
                S_MOVE: begin
                    r_cur   <= n_cur;
                    r_state <= S_DUTY;
                end
                S_DUTY: begin
                    if (slot_free) begin
                        r_state <= i_job_valid ? S_MUL : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job       <= i_job;
            r_sine      <= SINE_ROM[i_job.sine_idx];
            r_slew_prod <= 26'(i_job.age) * 26'(i_cfg.max_slew);
        end
        if (r_state == S_MUL) begin
            r_prod <= $signed({1'b0, i_cfg.amplitude}) * r_sine;
            r_limq <= lim_prod[39:30];
        end
        if (r_state == S_TGT) begin
            r_target <= r_job.is_sample ? sample_target : r_job.target;
        end
        if (r_state == S_MOVE) begin
            r_ang <= ang_clamped;
        end
        if ((r_state == S_DUTY) && slot_free) begin
            r_out_data <= {3'b000, r_ang, duty};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_move_then_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE) |=> ((r_state == S_DUTY) && (r_ang <= 8'd180)))
        else $error("clamped angle out of range after slew step");

    a_no_limit_reaches_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MOVE) && (i_cfg.max_slew == '0)) |=> (r_cur == $past(r_target)))
        else $error("angle did not reach target with slew limiting off");

    a_result_from_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_DUTY))
        else $error("result raised outside the duty step");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - testbench of the servo sine oscillator core
// Drives millisecond ticks and position commands, keeps its own copy of the
// oscillator, slew limiter and sine table, and checks every duty and angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import svo_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int QUIET_CYCLES = 40;
    localparam logic [63:0] TURN_Q30    = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [12:0] duty;
        logic [7:0]  angle;
    } t_servo_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [15:0]           i_s_axis_tdata;   // target_angle[9:0], zero fill
    logic                  i_s_axis_tuser;   // kind[0]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [23:0]           o_m_axis_tdata;   // duty[12:0], angle[20:13], zero fill
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    servo_sine_oscillator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // oscillator copy kept by the testbench
    t_cfg                osc_regs;
    int unsigned         osc_phase;
    int unsigned         osc_timer;
    int unsigned         osc_age;
    int                  osc_angle;
    logic signed [15:0]  sine_lut [SINE_ENTRIES];
    t_servo_result       pending_results [$];

    int  error_count;
    int  results_seen;
    int  cycle_count;
    int  rx_hold;
    int  rx_wait;
    int  rx_last_seen;
    bit  no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // quarter-wave reduction, taylor series in q30, rounded to q14
    function automatic logic signed [15:0] quarter_wave_sine(input int unsigned i);
        logic [63:0]        u;
        logic [63:0]        r;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic [63:0]        psum;
        logic [63:0]        nsum;
        logic [63:0]        mag;
        logic [1:0]         quad;
        logic signed [15:0] v;
        u    = (64'(i) << 32) / 64'(SINE_ENTRIES);
        quad = u[31:30];
        r    = u & (TURN_Q30 - 64'd1);
        if (quad[0]) begin
            r = TURN_Q30 - r;
        end
        x    = (r * HALF_PI_Q30) >> 30;
        x2   = (x * x) >> 30;
        t    = x;
        psum = x;
        nsum = 64'd0;
        for (int k = 1; k <= 6; k++) begin
            t = ((t * x2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
            if (k % 2 == 1) begin
                nsum += t;
            end else begin
                psum += t;
            end
        end
        mag = (psum > nsum) ? ((psum - nsum + 64'd32768) >> 16) : 64'd0;
        if (mag > 64'd16384) begin
            mag = 64'd16384;
        end
        v = mag[15:0];
        return quad[1] ? -v : v;
    endfunction

    task automatic reset_oscillator_copy();
        osc_regs.sample_period_ms = RST_SAMPLE_PERIOD;
        osc_regs.phase_step       = RST_PHASE_STEP;
        osc_regs.amplitude        = RST_AMPLITUDE;
        osc_regs.center_offset    = RST_CENTER_OFFSET;
        osc_regs.start_phase      = RST_START_PHASE;
        osc_regs.mode_bits        = RST_MODE_BITS;
        osc_regs.trim             = RST_TRIM;
        osc_regs.max_slew         = RST_MAX_SLEW;
        osc_phase = 0;
        osc_timer = 0;
        osc_age   = 0;
        osc_angle = 90;
    endtask

    // slew step, trim, clamp and duty of one servo write
    task automatic commit_angle(input int target);
        int          lim;
        int          diff;
        int          mag;
        int          ang;
        int unsigned step_limit;
        t_servo_result res;
        if (target > 511) target = 511;
        if (target < -512) target = -512;
        if (osc_regs.max_slew != 0) begin
            step_limit = (osc_age * int'(osc_regs.max_slew)) / 1000;
            lim  = (step_limit < 1) ? 1 : int'(step_limit);
            diff = target - osc_angle;
            mag  = (diff < 0) ? -diff : diff;
            if (mag > lim) begin
                osc_angle += (diff < 0) ? -lim : lim;
            end else begin
                osc_angle = target;
            end
        end else begin
            osc_angle = target;
        end
        osc_age = 0;
        ang = osc_angle + int'($signed(osc_regs.trim));
        if (ang < 0) ang = 0;
        if (ang > 180) ang = 180;
        res.duty  = 13'(((ang + 45) * 8191) / 1800);
        res.angle = 8'(ang);
        pending_results.push_back(res);
    endtask

    task automatic predict_servo_write(input logic kind, input logic signed [9:0] target);
        int unsigned p;
        int unsigned idx;
        int          prod;
        int          pos;
        if (kind) begin
            commit_angle(int'(target));
        end else begin
            if (osc_timer < 1023) osc_timer++;
            if (osc_age < 65535) osc_age++;
            if (osc_timer >= int'(osc_regs.sample_period_ms)) begin
                osc_timer = 0;
                if (!osc_regs.mode_bits[MODE_STOPPED]) begin
                    p    = (osc_phase + osc_regs.start_phase) & 32'hFFFF;
                    idx  = (p * SINE_ENTRIES) >> 16;
                    prod = int'(osc_regs.amplitude) * int'(sine_lut[idx]);
                    if (prod < 0) begin
                        pos = -((-prod + 8192) >> 14);
                    end else begin
                        pos = (prod + 8192) >> 14;
                    end
                    pos += int'($signed(osc_regs.center_offset));
                    if (osc_regs.mode_bits[MODE_REVERSED]) begin
                        pos = -pos;
                    end
                    commit_angle(pos + 90);
                end
                osc_phase = (osc_phase + osc_regs.phase_step) & 32'hFFFF;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            CFG_SAMPLE_PERIOD: osc_regs.sample_period_ms = value[9:0];
            CFG_PHASE_STEP:    osc_regs.phase_step       = value;
            CFG_AMPLITUDE:     osc_regs.amplitude        = value[7:0];
            CFG_CENTER_OFFSET: osc_regs.center_offset    = value[8:0];
            CFG_START_PHASE:   osc_regs.start_phase      = value;
            CFG_MODE_BITS:     osc_regs.mode_bits        = value[1:0];
            CFG_TRIM:          osc_regs.trim             = value[7:0];
            CFG_MAX_SLEW:      osc_regs.max_slew         = value[9:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_item(input logic kind, input logic [9:0] target_bits);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {6'd0, target_bits};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_servo_write(kind, $signed(target_bits));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(1'b0, 10'($urandom_range(0, 1023)));
    endtask

    // lets the block run dry, including ticks that produce nothing
    task automatic wait_quiet();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stall per transaction, or a long hold-off
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (results_seen != rx_last_seen) begin
                rx_last_seen = results_seen;
                rx_wait = no_idle ? 0 : $urandom_range(0, 4);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_servo_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected transaction: expected none, actual duty %0d angle %0d",
                         $time, o_m_axis_tdata[12:0], o_m_axis_tdata[20:13]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tdata[12:0] !== want.duty) begin
                    $display("%0t duty mismatch: expected %0d actual %0d",
                             $time, want.duty, o_m_axis_tdata[12:0]);
                    error_count++;
                end
                if (o_m_axis_tdata[20:13] !== want.angle) begin
                    $display("%0t angle mismatch: expected %0d actual %0d",
                             $time, want.angle, o_m_axis_tdata[20:13]);
                    error_count++;
                end
            end
        end
    end

    // position commands at the edges of the range, with trim extremes
    task automatic test_commands();
        send_item(1'b1, 10'h200);
        send_item(1'b1, 10'h1FF);
        send_item(1'b1, 10'h000);
        send_item(1'b1, 10'h3FF);
        wait_quiet();
        write_reg(CFG_TRIM, 16'(90));
        send_item(1'b1, 10'd90);
        wait_quiet();
        write_reg(CFG_TRIM, 16'(-128));
        send_item(1'b1, 10'd180);
        wait_quiet();
        write_reg(CFG_TRIM, 16'(127));
        send_item(1'b1, 10'h3A6);
        wait_quiet();
        write_reg(CFG_TRIM, 16'(0));
    endtask

    // sample on every tick, then stopped and reversed modes
    task automatic test_period_zero_modes();
        write_reg(CFG_SAMPLE_PERIOD, 16'd0);
        write_reg(CFG_PHASE_STEP, 16'd16384);
        write_reg(CFG_AMPLITUDE, 16'd180);
        send_ticks(4);
        wait_quiet();
        write_reg(CFG_MODE_BITS, 16'd1);
        send_ticks(2);
        send_item(1'b1, 10'd45);
        wait_quiet();
        write_reg(CFG_MODE_BITS, 16'd2);
        send_ticks(2);
        wait_quiet();
        write_reg(CFG_MODE_BITS, 16'd0);
    endtask

    // minimum step with a fresh command, wider steps as time builds up
    task automatic test_slew_limit();
        write_reg(CFG_MAX_SLEW, 16'd1);
        send_item(1'b1, 10'd180);
        send_item(1'b1, 10'd0);
        send_item(1'b1, 10'h200);
        wait_quiet();
        write_reg(CFG_SAMPLE_PERIOD, 16'd2);
        write_reg(CFG_MAX_SLEW, 16'd1023);
        send_ticks(4);
        wait_quiet();
        write_reg(CFG_MAX_SLEW, 16'd0);
    endtask

    // largest sample lands above the target range, reversed lands well below zero
    task automatic test_target_saturation();
        write_reg(CFG_SAMPLE_PERIOD, 16'd0);
        write_reg(CFG_PHASE_STEP, 16'd0);
        write_reg(CFG_AMPLITUDE, 16'd255);
        write_reg(CFG_CENTER_OFFSET, 16'(255));
        write_reg(CFG_START_PHASE, 16'(16384 - osc_phase));
        send_ticks(1);
        wait_quiet();
        write_reg(CFG_MODE_BITS, 16'd2);
        send_ticks(1);
        wait_quiet();
        write_reg(CFG_MODE_BITS, 16'd0);
        write_reg(CFG_CENTER_OFFSET, 16'(0));
    endtask

    // results held back until the queue fills and the input stalls
    task automatic test_output_backpressure();
        no_idle = 1'b1;
        rx_hold = 300;
        repeat (24) send_item(1'b1, 10'($urandom_range(0, 1023)));
        wait_quiet();
        no_idle = 1'b0;
    endtask

    // one sample after the longest period, with a long run of elapsed time
    task automatic test_longest_period();
        no_idle = 1'b1;
        write_reg(CFG_SAMPLE_PERIOD, 16'd1023);
        write_reg(CFG_AMPLITUDE, 16'd180);
        write_reg(CFG_MAX_SLEW, 16'd1000);
        send_ticks(1030);
        wait_quiet();
        no_idle = 1'b0;
    endtask

    task automatic program_random_settings(input int style);
        logic [9:0]  period;
        logic [15:0] step;
        logic [7:0]  amp;
        int          offset;
        int          trim_deg;
        logic [9:0]  slew;
        case ($urandom_range(0, 3))
            0:       period = 10'd0;
            1, 2:    period = 10'($urandom_range(1, 6));
            default: period = 10'($urandom_range(7, 40));
        endcase
        step     = 16'($urandom);
        amp      = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 180));
        offset   = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 511)) - 256
                                               : int'($urandom_range(0, 360)) - 180;
        trim_deg = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 255)) - 128
                                               : int'($urandom_range(0, 180)) - 90;
        slew     = ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom_range(1, 1023));
        if (style == 1) begin
            // top of the usual amplitude, offset and trim ranges, period 1, slew 1000
            period = 10'd1;   amp = 8'd180; offset = 180; trim_deg = 90; slew = 10'd1000;
        end else if (style == 2) begin
            // bottom of the usual amplitude, offset, trim and slew ranges, period 1
            period = 10'd1;   amp = 8'd0;   offset = -180; trim_deg = -90; slew = 10'd0;
        end
        write_reg(CFG_SAMPLE_PERIOD, 16'(period));
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_AMPLITUDE, 16'(amp));
        write_reg(CFG_CENTER_OFFSET, 16'(offset));
        write_reg(CFG_START_PHASE, 16'($urandom));
        write_reg(CFG_MODE_BITS, 16'($urandom_range(0, 3)));
        write_reg(CFG_TRIM, 16'(trim_deg));
        write_reg(CFG_MAX_SLEW, 16'(slew));
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 10; ph++) begin
            program_random_settings((ph < 2) ? ph + 1 : 0);
            no_idle = (ph % 3 == 2);
            repeat (62) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_item(1'b1, 10'($urandom_range(0, 1023)));
                end else begin
                    send_item(1'b0, 10'($urandom_range(0, 1023)));
                end
            end
            wait_quiet();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        error_count     = 0;
        results_seen    = 0;
        cycle_count     = 0;
        rx_hold         = 0;
        rx_wait         = 0;
        rx_last_seen    = 0;
        no_idle         = 1'b0;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            sine_lut[i] = quarter_wave_sine(i);
        end
        reset_oscillator_copy();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_commands();
        test_period_zero_modes();
        test_slew_limit();
        test_target_saturation();
        test_output_backpressure();
        test_longest_period();
        test_random_traffic();

        wait_quiet();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
